[design/tcw_pkg.sv]
// package for the text console writer: screen geometry, field widths,
// action codes and the sequencer state type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths
    localparam int ADDR_W  = 11;
    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 16;
    localparam int COUNT_W = 16;
    localparam int COL_W   = $clog2(COLUMNS);

    // character and attribute constants
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] BG_THRESHOLD = 8'h10;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_BGND  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SCROLL,
        S_SCROLL_CLR,
        S_PUT,
        S_NL,
        S_CHR_WR,
        S_CLEAR,
        S_BG,
        S_READ,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[design/text_console_writer_unit.sv]
// text console writer top level: screen memory, cursor and message sequencer
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps
`default_nettype none

// An item is taken at a clock edge with start high and busy low; its single
// result shows on the o_ ports for one cycle with o_valid high and cannot be
// held off, so the receiver must take it then. busy is high from reset for a
// clearing pass while the screen memory is zeroed. A plain character passes
// through S_DECODE, S_PUT and S_CHR_WR, a read through S_DECODE and S_READ,
// and a write that changes nothing, a read out of range or a background
// change below the threshold goes from S_DECODE straight to S_DONE; busy falls
// as the result shows, so the next item may be started in that cycle. Longer
// work is done one cell a cycle on the memory's single write port: a newline
// sweeps the rest of the row, a clear and a background change sweep every
// cell, and a write with the cursor past the last cell first scrolls the screen.
module text_console_writer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_action,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_char_code,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_attribute,
    input  wire logic                          i_final_req,
    input  wire logic [tcw_pkg::ADDR_W-1:0]    i_cell_index,
    output logic                               o_valid,
    output logic      [tcw_pkg::ADDR_W-1:0]    o_cursor,
    output logic      [tcw_pkg::BYTE_W-1:0]    o_cell_char,
    output logic      [tcw_pkg::BYTE_W-1:0]    o_cell_attribute,
    output logic      [tcw_pkg::COUNT_W-1:0]   o_written_count
);

    import tcw_pkg::*;

    // control registers
    t_state               r_state,   n_state;
    logic [ADDR_W-1:0]    r_ptr,     n_ptr;
    logic [ADDR_W-1:0]    r_wptr,    n_wptr;
    logic                 r_pend,    n_pend;
    logic [ADDR_W-1:0]    r_end,     n_end;
    logic [ADDR_W-1:0]    r_cursor,  n_cursor;
    logic [COL_W-1:0]     r_col,     n_col;
    logic [COUNT_W-1:0]   r_count,   n_count;
    logic                 r_stopped, n_stopped;
    logic                 r_out_valid, n_out_valid;

    // item and result payload registers
    t_action              r_action,  n_action;
    logic [BYTE_W-1:0]    r_char,    n_char;
    logic [BYTE_W-1:0]    r_attr,    n_attr;
    logic                 r_final,   n_final;
    logic [ADDR_W-1:0]    r_index,   n_index;
    logic [BYTE_W-1:0]    r_rd_char, n_rd_char;
    logic [BYTE_W-1:0]    r_rd_attr, n_rd_attr;
    logic [ADDR_W-1:0]    r_out_cursor, n_out_cursor;
    logic [BYTE_W-1:0]    r_out_char,   n_out_char;
    logic [BYTE_W-1:0]    r_out_attr,   n_out_attr;
    logic [COUNT_W-1:0]   r_out_count,  n_out_count;

    // memory port
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;

    logic                 accept;
    logic                 rmw_done;
    logic                 fill_done;
    logic [BYTE_W-1:0]    bg_attr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept    = start && (r_state == S_IDLE);
    assign rmw_done  = (r_ptr == r_end) && !r_pend;
    assign fill_done = (r_ptr == r_end);
    assign bg_attr   = {4'h0, ram_rdata[CELL_W-5:BYTE_W]} + r_attr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (fill_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_action)
                    ACT_WRITE: begin
                        if (r_stopped || r_char == '0) begin
                            n_state = S_DONE;
                        end else if (r_cursor >= ADDR_W'(CELLS)) begin
                            n_state = S_SCROLL;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    ACT_CLEAR: n_state = S_CLEAR;
                    ACT_BGND: begin
                        n_state = (r_attr >= BG_THRESHOLD) ? S_BG : S_DONE;
                    end
                    ACT_READ: begin
                        n_state = (r_index < ADDR_W'(CELLS)) ? S_READ : S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCROLL: begin
                if (rmw_done) n_state = S_SCROLL_CLR;
            end
            S_SCROLL_CLR: begin
                if (fill_done) n_state = S_PUT;
            end
            S_PUT: begin
                n_state = (r_char == NEWLINE_CODE) ? S_NL : S_CHR_WR;
            end
            S_NL: begin
                if (rmw_done) n_state = S_DONE;
            end
            S_CHR_WR: n_state = S_DONE;
            S_CLEAR: begin
                if (fill_done) n_state = S_DONE;
            end
            S_BG: begin
                if (rmw_done) n_state = S_DONE;
            end
            S_READ:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory port and result
    always_comb begin
        n_ptr        = r_ptr;
        n_wptr       = r_wptr;
        n_pend       = r_pend;
        n_end        = r_end;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_count      = r_count;
        n_stopped    = r_stopped;
        n_out_valid  = 1'b0;
        n_action     = r_action;
        n_char       = r_char;
        n_attr       = r_attr;
        n_final      = r_final;
        n_index      = r_index;
        n_rd_char    = r_rd_char;
        n_rd_attr    = r_rd_attr;
        n_out_cursor = r_out_cursor;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_ptr;
        ram_wdata    = '0;
        ram_raddr    = r_ptr;

        case (r_state)
            // zero fill sweeps: reset pass, clear, bottom row after scroll
            S_INIT, S_CLEAR, S_SCROLL_CLR: begin
                if (!fill_done) begin
                    ram_we = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                end else if (r_state == S_SCROLL_CLR) begin
                    n_cursor = r_cursor - ADDR_W'(COLUMNS);
                end
            end
            // take the item
            S_IDLE: begin
                if (accept) begin
                    n_action  = t_action'(i_action);
                    n_char    = i_char_code;
                    n_attr    = i_attribute;
                    n_final   = i_final_req;
                    n_index   = i_cell_index;
                    n_rd_char = '0;
                    n_rd_attr = '0;
                end
            end
            // set up the work for the item
            S_DECODE: begin
                n_ptr  = '0;
                n_pend = 1'b0;
                case (r_action)
                    ACT_WRITE: begin
                        n_end = ADDR_W'(CELLS - COLUMNS);
                        if (!r_stopped) begin
                            if (r_char == '0) begin
                                n_stopped = 1'b1;
                            end else if (r_count != '1) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        n_end    = ADDR_W'(CELLS);
                        n_cursor = '0;
                        n_col    = '0;
                    end
                    ACT_BGND: begin
                        n_end    = ADDR_W'(CELLS);
                        n_cursor = '0;
                        n_col    = '0;
                    end
                    ACT_READ: ram_raddr = r_index;
                    default: ;
                endcase
            end
            // read-modify-write sweeps, one cell issued and one written a cycle
            S_SCROLL, S_NL, S_BG: begin
                if (r_ptr != r_end) begin
                    ram_raddr = (r_state == S_SCROLL) ? r_ptr + ADDR_W'(COLUMNS) : r_ptr;
                    n_ptr     = r_ptr + 1'b1;
                    n_wptr    = r_ptr;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wptr;
                    case (r_state)
                        S_SCROLL: ram_wdata = ram_rdata;
                        S_NL:     ram_wdata = {ram_rdata[CELL_W-1:BYTE_W], 8'h00};
                        default:  ram_wdata = {bg_attr, ram_rdata[BYTE_W-1:0]};
                    endcase
                end
                if (r_state == S_NL && rmw_done) begin
                    n_cursor = r_end;
                    n_col    = '0;
                end
                // bottom row fill runs on to the last cell
                if (r_state == S_SCROLL && rmw_done) begin
                    n_end = ADDR_W'(CELLS);
                end
            end
            // place the character, or start the newline sweep
            S_PUT: begin
                ram_raddr = r_cursor;
                n_ptr     = r_cursor;
                n_pend    = 1'b0;
                n_end     = r_cursor + ADDR_W'(COLUMNS) - ADDR_W'(r_col);
            end
            S_CHR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cursor;
                ram_wdata = {ram_rdata[CELL_W-1:BYTE_W] | r_attr, r_char};
                n_cursor  = r_cursor + 1'b1;
                n_col     = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
            end
            S_READ: begin
                n_rd_char = ram_rdata[BYTE_W-1:0];
                n_rd_attr = ram_rdata[CELL_W-1:BYTE_W];
            end
            // present the result, end the message on a final write item
            S_DONE: begin
                n_out_valid  = 1'b1;
                n_out_cursor = r_cursor;
                n_out_char   = r_rd_char;
                n_out_attr   = r_rd_attr;
                n_out_count  = r_count;
                if (r_action == ACT_WRITE && r_final) begin
                    n_count   = '0;
                    n_stopped = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_wptr      <= '0;
            r_pend      <= 1'b0;
            r_end       <= ADDR_W'(CELLS);
            r_cursor    <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_wptr      <= n_wptr;
            r_pend      <= n_pend;
            r_end       <= n_end;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_char       <= n_char;
        r_attr       <= n_attr;
        r_final      <= n_final;
        r_index      <= n_index;
        r_rd_char    <= n_rd_char;
        r_rd_attr    <= n_rd_attr;
        r_out_cursor <= n_out_cursor;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
        r_out_count  <= n_out_count;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_cursor         = r_out_cursor;
    assign o_cell_char      = r_out_char;
    assign o_cell_attribute = r_out_attr;
    assign o_written_count  = r_out_count;

endmodule

`default_nettype wire

[design/tcw_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
